// ----- hdl/pidpc_pkg.sv -----
// Shared types, codes and constants for the PID position controller.
package pidpc_pkg;

   localparam int TRAJECTORY_DEPTH_DEFAULT = 4096;
   localparam int MAX_TRAJ_LEN             = 4096;

   localparam int POS_W     = 24;
   localparam int ERR_W     = 25;
   localparam int DIFF_W    = 26;
   localparam int INTEG_W   = 40;
   localparam int GAIN_W    = 16;
   localparam int CMD_W     = 16;
   localparam int INDEX_W   = 12;
   localparam int LEN_W     = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [GAIN_W-1:0] KP_RESET  = 16'sd3584;
   localparam logic signed [GAIN_W-1:0] KI_RESET  = 16'sd0;
   localparam logic signed [GAIN_W-1:0] KD_RESET  = 16'sd2560;
   localparam logic [LEN_W-1:0]         LEN_RESET = 13'd4096;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_MODE  = 2'd2,
      OP_HOLD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_HOLD  = 2'd1,
      MODE_TRACK = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP  = 2'd0,
      CSR_KI  = 2'd1,
      CSR_KD  = 2'd2,
      CSR_LEN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic prod_load;
      logic out_load;
   } pipe_en_type;

   typedef struct packed {
      logic                 command_valid;
      logic [1:0]           mode_now;
      logic [INDEX_W-1:0]   track_position;
      logic                 track_finished;
   } rsp_meta_type;

endpackage

// ----- hdl/pidpc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pidpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/pidpc_pid_math.sv -----
// PID product stage and sum, round and saturate stage.
module pidpc_pid_math (
   input  logic                                    clock,
   input  pidpc_pkg::pipe_en_type                  en,
   input  logic signed [pidpc_pkg::ERR_W-1:0]      err,
   input  logic signed [pidpc_pkg::DIFF_W-1:0]     diff,
   input  logic signed [pidpc_pkg::INTEG_W-1:0]    integ,
   input  logic signed [pidpc_pkg::GAIN_W-1:0]     kp,
   input  logic signed [pidpc_pkg::GAIN_W-1:0]     ki,
   input  logic signed [pidpc_pkg::GAIN_W-1:0]     kd,
   output logic signed [pidpc_pkg::CMD_W-1:0]      cmd
);
   import pidpc_pkg::*;

   localparam int PP_W  = ERR_W + GAIN_W;
   localparam int PI_W  = INTEG_W + GAIN_W;
   localparam int PD_W  = DIFF_W + GAIN_W;
   localparam int SUM_W = PI_W + 2;
   localparam int SH_W  = SUM_W - 16;

   logic signed [PP_W-1:0]  prod_p_ff, prod_p_in;
   logic signed [PI_W-1:0]  prod_i_ff, prod_i_in;
   logic signed [PD_W-1:0]  prod_d_ff, prod_d_in;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] rounded;
   logic signed [SH_W-1:0]  shifted;
   logic signed [CMD_W-1:0] cmd_ff, cmd_in;

   assign prod_p_in = PP_W'(err)  * PP_W'(kp);
   assign prod_i_in = PI_W'(integ) * PI_W'(ki);
   assign prod_d_in = PD_W'(diff) * PD_W'(kd);

   always_ff @(posedge clock) begin
      if (en.prod_load) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
      if (en.out_load) begin
         cmd_ff <= cmd_in;
      end
   end

   always_comb begin
      sum     = SUM_W'(prod_p_ff) + SUM_W'(prod_i_ff) + SUM_W'(prod_d_ff);
      rounded = sum + SUM_W'(32768);
      shifted = rounded[SUM_W-1:16];
      if (shifted > SH_W'(32767)) begin
         cmd_in = 16'sh7FFF;
      end else if (shifted < -SH_W'(32768)) begin
         cmd_in = 16'sh8000;
      end else begin
         cmd_in = shifted[CMD_W-1:0];
      end
   end

   assign cmd = cmd_ff;

endmodule

// ----- hdl/pid_position_controller_with_tracking_unit.sv -----
// Top level of the PID position controller with trajectory tracking.
// Request channel (req_*): one word per item; op selects a control tick, a
// trajectory table write, a mode change or a new hold reference. Response
// channel (rsp_*): exactly one word per request word, in order, carrying the
// saturated current command, its valid flag, the mode and the trajectory
// position after the item, and the track-finished flag.
// CSR port (csr_*): plain writes of the gains and the trajectory length,
// taken in the cycle csr_write_enable is high; write only while idle.
// An accepted word passes the input register, product register and result
// register in order to the response word. Throughput: one word per cycle
// while rsp_ready allows; the controller state and the trajectory RAM are
// updated in the input stage, so ticks follow each other without gaps.
// The trajectory RAM is read ahead at the next track position,
// with a bypass for a write to that entry.
// Reset: mode idle, hold reference, integral, previous error and track
// position cleared, gains and length to their defaults; table contents stay
// undefined until written. When rsp_ready is low the pipeline holds; stages
// that are empty still take words, so up to three words sit in flight.
module pid_position_controller_with_tracking_unit #(
   parameter int TRAJECTORY_DEPTH = pidpc_pkg::TRAJECTORY_DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_op,
   input  logic signed [pidpc_pkg::POS_W-1:0]      req_measured_position,
   input  logic [pidpc_pkg::INDEX_W-1:0]           req_entry_index,
   input  logic signed [pidpc_pkg::POS_W-1:0]      req_position_value,
   input  logic [1:0]                              req_new_mode,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pidpc_pkg::CMD_W-1:0]      rsp_current_command,
   output logic                                    rsp_command_valid,
   output logic [1:0]                              rsp_mode_now,
   output logic [pidpc_pkg::INDEX_W-1:0]           rsp_track_position,
   output logic                                    rsp_track_finished,
   input  logic                                    csr_write_enable,
   input  logic [pidpc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pidpc_pkg::GAIN_W-1:0]            csr_write_data
);
   import pidpc_pkg::*;

   localparam int AW      = (TRAJECTORY_DEPTH > 1) ? $clog2(TRAJECTORY_DEPTH) : 1;
   localparam int LEN_CAP = (TRAJECTORY_DEPTH < MAX_TRAJ_LEN) ? TRAJECTORY_DEPTH
                                                              : MAX_TRAJ_LEN;

   // csr registers
   logic signed [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [LEN_W-1:0]         len_ff;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3, fire1;
   pipe_en_type pipe_en;

   // input register
   op_type                    op_ff;
   logic signed [POS_W-1:0]   meas_ff;
   logic [INDEX_W-1:0]        entry_ff;
   logic signed [POS_W-1:0]   value_ff;
   logic [1:0]                new_mode_ff;

   // controller state
   mode_type                  mode_ff, mode_in;
   logic signed [POS_W-1:0]   hold_ref_ff, hold_ref_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   prev_ff, prev_in;
   logic [INDEX_W-1:0]        index_ff, index_in;

   // table access
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr, ram_rd_addr;
   logic [POS_W-1:0]          ram_rd_data;
   logic [AW+INDEX_W-1:0]     wr_addr_ext, rd_addr_ext;
   logic                      fwd_hit_ff, fwd_hit_in;
   logic signed [POS_W-1:0]   fwd_data_ff;
   logic signed [POS_W-1:0]   table_ref;

   // stage 1 datapath
   logic signed [POS_W-1:0]   ref_pos;
   logic signed [ERR_W-1:0]   err;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [INTEG_W:0]   integ_sum;
   logic [LEN_W-1:0]          eff_len;
   logic                      last_entry;
   rsp_meta_type              meta1, meta2_ff, meta3_ff;
   logic signed [CMD_W-1:0]   cmd;

   assign en3       = !v3_ff || rsp_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign fire1     = v1_ff && en2;

   assign pipe_en.prod_load = en2;
   assign pipe_en.out_load  = en3;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= KP_RESET;
         ki_ff  <= KI_RESET;
         kd_ff  <= KD_RESET;
         len_ff <= LEN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KP:  kp_ff  <= csr_write_data;
            CSR_KI:  ki_ff  <= csr_write_data;
            CSR_KD:  kd_ff  <= csr_write_data;
            CSR_LEN: len_ff <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(LEN_CAP)) begin
         eff_len = LEN_W'(LEN_CAP);
      end else begin
         eff_len = len_ff;
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op_ff       <= op_type'(req_op);
         meas_ff     <= req_measured_position;
         entry_ff    <= req_entry_index;
         value_ff    <= req_position_value;
         new_mode_ff <= req_new_mode;
      end
      if (en2) meta2_ff <= meta1;
      if (en3) meta3_ff <= meta2_ff;
   end

   // trajectory table
   assign table_ref = fwd_hit_ff ? fwd_data_ff : signed'(ram_rd_data);
   assign ref_pos   = (mode_ff == MODE_TRACK) ? table_ref : hold_ref_ff;

   assign wr_addr_ext = {{AW{1'b0}}, entry_ff};
   assign rd_addr_ext = {{AW{1'b0}}, index_in};
   assign ram_wr_addr = wr_addr_ext[AW-1:0];
   assign ram_rd_addr = rd_addr_ext[AW-1:0];
   assign ram_wr_en   = fire1 && (op_ff == OP_WRITE)
                        && (32'(entry_ff) < TRAJECTORY_DEPTH);
   assign fwd_hit_in  = ram_wr_en && (ram_wr_addr == ram_rd_addr);

   pidpc_ram #(
      .WIDTH (POS_W),
      .DEPTH (TRAJECTORY_DEPTH),
      .AW    (AW)
   ) u_traj_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (value_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= fwd_hit_in;
      end
      fwd_data_ff <= value_ff;
   end

   // stage 1: error, integral and state update
   assign err        = ERR_W'(ref_pos) - ERR_W'(meas_ff);
   assign diff       = DIFF_W'(err) - DIFF_W'(prev_ff);
   assign integ_sum  = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(err);
   assign last_entry = (LEN_W'(index_ff) + LEN_W'(1)) >= eff_len;

   always_comb begin
      mode_in     = mode_ff;
      hold_ref_in = hold_ref_ff;
      integ_in    = integ_ff;
      prev_in     = prev_ff;
      index_in    = index_ff;
      meta1       = '0;
      if (fire1) begin
         case (op_ff)
            OP_TICK: begin
               if (mode_ff == MODE_IDLE) begin
                  integ_in = '0;
                  prev_in  = '0;
                  index_in = '0;
               end else begin
                  meta1.command_valid = 1'b1;
                  prev_in             = err;
                  if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
                     integ_in = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                                   : {1'b0, {(INTEG_W-1){1'b1}}};
                  end else begin
                     integ_in = integ_sum[INTEG_W-1:0];
                  end
                  if (mode_ff == MODE_TRACK) begin
                     if (last_entry) begin
                        mode_in              = MODE_HOLD;
                        hold_ref_in          = table_ref;
                        index_in             = '0;
                        meta1.track_finished = 1'b1;
                     end else begin
                        index_in = index_ff + INDEX_W'(1);
                     end
                  end
               end
            end
            OP_MODE: begin
               if (new_mode_ff inside {MODE_IDLE, MODE_HOLD, MODE_TRACK}) begin
                  mode_in = mode_type'(new_mode_ff);
               end
            end
            OP_HOLD: hold_ref_in = value_ff;
            default: ;
         endcase
      end
      meta1.mode_now       = mode_in;
      meta1.track_position = index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         hold_ref_ff <= '0;
         integ_ff    <= '0;
         prev_ff     <= '0;
         index_ff    <= '0;
      end else begin
         mode_ff     <= mode_in;
         hold_ref_ff <= hold_ref_in;
         integ_ff    <= integ_in;
         prev_ff     <= prev_in;
         index_ff    <= index_in;
      end
   end

   // stages 2 and 3: products, sum, round, saturate
   pidpc_pid_math u_math (
      .clock (clock),
      .en    (pipe_en),
      .err   (err),
      .diff  (diff),
      .integ (integ_in),
      .kp    (kp_ff),
      .ki    (ki_ff),
      .kd    (kd_ff),
      .cmd   (cmd)
   );

   assign rsp_valid           = v3_ff;
   assign rsp_current_command = meta3_ff.command_valid ? cmd : '0;
   assign rsp_command_valid   = meta3_ff.command_valid;
   assign rsp_mode_now        = meta3_ff.mode_now;
   assign rsp_track_position  = meta3_ff.track_position;
   assign rsp_track_finished  = meta3_ff.track_finished;

endmodule
